### sv/rtei_pkg.sv
// Shared constants and types for the resend timeout estimator.
package rtei_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CNT_W = COUNT_BITS;
  localparam int unsigned Q_W = 16;
  localparam int unsigned NUM_W = 34;
  localparam int unsigned DEN_W = COUNT_BITS + 1;
  localparam int unsigned REM_W = COUNT_BITS + 2;
  localparam int unsigned STEP_W = $clog2(Q_W + 1);
  localparam int unsigned CAND_W = 12;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [CAND_W-1:0] TIMEOUT_HI = 12'd3000;
  localparam logic [CAND_W-1:0] TIMEOUT_LO = 12'd333;
  localparam logic [15:0] SAMPLE_SAT = 16'hFFFF;
  localparam logic [DEN_W-1:0] MAX_SCALE_DEN = DEN_W'(10);

  localparam logic ACTION_ACK = 1'b0;
  localparam logic ACTION_CLOSE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### sv/rtei_div.sv
// Radix-2 restoring divider with a saturating 16-bit quotient.
module rtei_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rtei_pkg::NUM_W-1:0]  num_i,
  input  logic [rtei_pkg::DEN_W-1:0]  den_i,
  output rtei_pkg::div_status_t       status_o,
  output logic [rtei_pkg::Q_W-1:0]    quot_o
);
  import rtei_pkg::*;

  localparam int unsigned CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [Q_W-1:0]    low_q, low_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [REM_W-1:0]  trial;
  logic              fits;
  logic              sat;

  assign sat   = CMP_W'(num_i) >= (CMP_W'(den_i) << Q_W);
  assign trial = {rem_q[REM_W-2:0], low_q[Q_W-1]};
  assign fits  = trial >= REM_W'(den_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    if (start_i) begin
      den_d = den_i;
      if (sat) begin
        low_d  = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = REM_W'(num_i >> Q_W);
        low_d  = num_i[Q_W-1:0];
        step_d = STEP_W'(Q_W);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = fits ? trial - REM_W'(den_q) : trial;
      low_d  = {low_q[Q_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      low_q  <= '0;
      den_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      low_q  <= low_d;
      den_q  <= den_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = low_q;

endmodule

### sv/resend_timeout_estimator_unit.sv
// Top level of the resend timeout estimator.
// Accept to result valid: an acknowledgement that adds to the average passes update,
// divider start and wait; a period end that recomputes the timeout passes close, divider
// wait and apply, the wait ending at once when the scaled maximum saturates the 16-step
// shared divider; any other word passes update or close only. One word is in flight; the
// next is accepted the cycle after the result is loaded; a result waiting in the output
// register holds it. Reset clears the period statistics, loads the timeout with 1000 ms.
module resend_timeout_estimator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] send_time_ms_i,
  input  logic [31:0] first_send_time_ms_i,
  input  logic        was_resent_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] resend_timeout_ms_o,
  output logic [15:0] average_ping_ms_o,
  output logic [15:0] min_ping_ms_o,
  output logic [15:0] max_ping_ms_o,
  output logic [15:0] last_period_average_ms_o,
  output logic        sample_taken_o
);
  import rtei_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_UPDATE, S_AVG_START, S_AVG_WAIT, S_CLOSE, S_CAND_WAIT, S_APPLY, S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic              action_q, action_d;
  logic [15:0]       sample_q, sample_d;
  logic              take_q, take_d;
  logic [31:0]       total_q, total_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [15:0]       avg_q, avg_d;
  logic [15:0]       min_q, min_d;
  logic [15:0]       max_q, max_d;
  logic [15:0]       timeout_q, timeout_d;
  logic [15:0]       last_q, last_d;
  logic [CAND_W-1:0] cand_q, cand_d;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       o_timeout_q, o_timeout_d;
  logic [15:0]       o_avg_q, o_avg_d;
  logic [15:0]       o_min_q, o_min_d;
  logic [15:0]       o_max_q, o_max_d;
  logic [15:0]       o_last_q, o_last_d;
  logic              o_taken_q, o_taken_d;

  logic [31:0]       diff;
  logic [15:0]       sample_sat;
  logic [32:0]       total_sum;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  div_status_t       div_st;
  logic [Q_W-1:0]    div_quot;
  logic [17:0]       avg_x3;
  logic [17:0]       cand_min;
  logic [16:0]       mean_sum;
  logic [15:0]       mean_half;
  logic              close_live;

  assign diff       = now_ms_i - (was_resent_i ? first_send_time_ms_i : send_time_ms_i);
  assign sample_sat = (|diff[31:16]) ? SAMPLE_SAT : diff[15:0];
  assign total_sum  = {1'b0, total_q} + 33'(sample_q);
  assign close_live = (max_q != '0) && (avg_q != '0);

  assign div_start = (state_q == S_AVG_START) ||
                     ((state_q == S_CLOSE) && (count_q != '0) && close_live);
  assign div_num   = (state_q == S_CLOSE) ?
                     (NUM_W'({max_q, 3'b000}) + NUM_W'({max_q, 2'b00}) + NUM_W'(max_q)) :
                     (NUM_W'({total_q, 1'b0}) + NUM_W'(count_q));
  assign div_den   = (state_q == S_CLOSE) ? MAX_SCALE_DEN : DEN_W'({count_q, 1'b0});

  assign avg_x3    = 18'({avg_q, 1'b0}) + 18'(avg_q);
  assign cand_min  = (avg_x3 < 18'(div_quot)) ? avg_x3 : 18'(div_quot);
  assign mean_sum  = 17'(timeout_q) + 17'(cand_q);
  assign mean_half = mean_sum[16:1];

  rtei_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_st),
    .quot_o   (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    sample_d    = sample_q;
    take_d      = take_q;
    total_d     = total_q;
    count_d     = count_q;
    avg_d       = avg_q;
    min_d       = min_q;
    max_d       = max_q;
    timeout_d   = timeout_q;
    last_d      = last_q;
    cand_d      = cand_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_timeout_d = o_timeout_q;
    o_avg_d     = o_avg_q;
    o_min_d     = o_min_q;
    o_max_d     = o_max_q;
    o_last_d    = o_last_q;
    o_taken_d   = o_taken_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          action_d = action_i;
          sample_d = sample_sat;
          take_d   = (action_i == ACTION_ACK) && (!was_resent_i || (count_q == '0));
          state_d  = (action_i == ACTION_CLOSE) ? S_CLOSE : S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_d = S_DONE;
        if (take_q) begin
          if (sample_q < min_q) begin
            min_d = sample_q;
          end
          if (sample_q > max_q) begin
            max_d = sample_q;
          end
          if (count_q != '1) begin
            total_d = total_sum[32] ? '1 : total_sum[31:0];
            count_d = count_q + CNT_W'(1);
            state_d = S_AVG_START;
          end
        end
      end
      S_AVG_START: begin
        state_d = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (div_st.done) begin
          avg_d   = div_quot;
          state_d = S_DONE;
        end
      end
      S_CLOSE: begin
        state_d = S_DONE;
        if (count_q != '0) begin
          if (close_live) begin
            state_d = S_CAND_WAIT;
          end else begin
            total_d = '0;
            count_d = '0;
            avg_d   = '0;
            min_d   = SAMPLE_SAT;
            max_d   = '0;
          end
        end
      end
      S_CAND_WAIT: begin
        if (div_st.done) begin
          if (cand_min > 18'(TIMEOUT_HI)) begin
            cand_d = TIMEOUT_HI;
          end else if (cand_min < 18'(TIMEOUT_LO)) begin
            cand_d = TIMEOUT_LO;
          end else begin
            cand_d = cand_min[CAND_W-1:0];
          end
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        timeout_d = (16'(cand_q) < mean_half) ? 16'(cand_q) : mean_half;
        last_d    = avg_q;
        total_d   = '0;
        count_d   = '0;
        avg_d     = '0;
        min_d     = SAMPLE_SAT;
        max_d     = '0;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_timeout_d = timeout_q;
          o_avg_d     = avg_q;
          o_min_d     = min_q;
          o_max_d     = max_q;
          o_last_d    = last_q;
          o_taken_d   = take_q && (action_q == ACTION_ACK);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      timeout_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      action_q    <= ACTION_ACK;
      sample_q    <= '0;
      take_q      <= 1'b0;
      total_q     <= '0;
      count_q     <= '0;
      avg_q       <= '0;
      min_q       <= SAMPLE_SAT;
      max_q       <= '0;
      timeout_q   <= TIMEOUT_RESET;
      last_q      <= '0;
      cand_q      <= '0;
      out_valid_q <= 1'b0;
      o_timeout_q <= '0;
      o_avg_q     <= '0;
      o_min_q     <= '0;
      o_max_q     <= '0;
      o_last_q    <= '0;
      o_taken_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      sample_q    <= sample_d;
      take_q      <= take_d;
      total_q     <= total_d;
      count_q     <= count_d;
      avg_q       <= avg_d;
      min_q       <= min_d;
      max_q       <= max_d;
      timeout_q   <= timeout_d;
      last_q      <= last_d;
      cand_q      <= cand_d;
      out_valid_q <= out_valid_d;
      o_timeout_q <= o_timeout_d;
      o_avg_q     <= o_avg_d;
      o_min_q     <= o_min_d;
      o_max_q     <= o_max_d;
      o_last_q    <= o_last_d;
      o_taken_q   <= o_taken_d;
    end
  end

  assign in_ready_o               = (state_q == S_IDLE);
  assign out_valid_o              = out_valid_q;
  assign resend_timeout_ms_o      = o_timeout_q;
  assign average_ping_ms_o        = o_avg_q;
  assign min_ping_ms_o            = o_min_q;
  assign max_ping_ms_o            = o_max_q;
  assign last_period_average_ms_o = o_last_q;
  assign sample_taken_o           = o_taken_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word accepted while a word is in flight");

  a_div_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_st.busy && !div_st.done)
    else $error("divider active while idle");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_AVG_WAIT) || (state_q == S_CAND_WAIT))
    else $error("divider result with no state waiting for it");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q))
    else $error("period minimum above maximum");

  a_timeout_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> (cand_q >= TIMEOUT_LO) && (cand_q <= TIMEOUT_HI))
    else $error("candidate timeout outside its range");

endmodule

### tb/timeout_estimate_checker.sv
// Checker for the resend timeout estimator: predicts each result word and compares it.
`timescale 1ns / 100ps
module timeout_estimate_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        action_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] send_time_ms_i,
  input  logic [31:0] first_send_time_ms_i,
  input  logic        was_resent_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] resend_timeout_ms_i,
  input  logic [15:0] average_ping_ms_i,
  input  logic [15:0] min_ping_ms_i,
  input  logic [15:0] max_ping_ms_i,
  input  logic [15:0] last_period_average_ms_i,
  input  logic        sample_taken_i,
  output int unsigned mismatch_count_o,
  output int unsigned words_pending_o
);
  import rtei_pkg::*;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] average;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [15:0] prev_average;
    logic        taken;
  } estimate_t;

  logic [31:0]      period_total;
  logic [CNT_W-1:0] period_count;
  logic [15:0]      period_avg;
  logic [15:0]      period_min;
  logic [15:0]      period_max;
  logic [15:0]      timeout_ms;
  logic [15:0]      prev_avg;
  estimate_t        expected_q[$];

  task automatic clear_period();
    period_total = '0;
    period_count = '0;
    period_avg   = '0;
    period_min   = SAMPLE_SAT;
    period_max   = '0;
  endtask

  task automatic estimate_next(input logic act, input logic [31:0] now, input logic [31:0] sent,
                               input logic [31:0] first, input logic resent,
                               output estimate_t res);
    logic [31:0] delta;
    logic [15:0] smp;
    logic [63:0] sum;
    logic [63:0] avg_wide;
    logic [31:0] by_avg;
    logic [31:0] by_max;
    logic [31:0] cand;
    logic [31:0] nxt;
    res.taken = 1'b0;
    if (act == ACTION_ACK) begin
      if (!resent || period_count == '0) begin
        delta = resent ? now - first : now - sent;
        smp = (delta > 32'(SAMPLE_SAT)) ? SAMPLE_SAT : delta[15:0];
        if (period_count < {CNT_W{1'b1}}) begin
          sum = 64'(period_total) + 64'(smp);
          if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
          period_total = sum[31:0];
          period_count = period_count + 1'b1;
          avg_wide = (2 * sum + 64'(period_count)) / (2 * 64'(period_count));
          period_avg = (avg_wide > 64'(SAMPLE_SAT)) ? SAMPLE_SAT : avg_wide[15:0];
        end
        if (smp < period_min) period_min = smp;
        if (smp > period_max) period_max = smp;
        res.taken = 1'b1;
      end
    end else if (period_count != '0) begin
      if (period_max != '0 && period_avg != '0) begin
        by_avg = 32'(period_avg) * 32'd3;
        by_max = (32'(period_max) * 32'd13) / 32'd10;
        cand = (by_avg < by_max) ? by_avg : by_max;
        if (cand > 32'(TIMEOUT_HI)) cand = 32'(TIMEOUT_HI);
        if (cand < 32'(TIMEOUT_LO)) cand = 32'(TIMEOUT_LO);
        nxt = (32'(timeout_ms) + cand) / 32'd2;
        if (cand < nxt) nxt = cand;
        timeout_ms = nxt[15:0];
        prev_avg = period_avg;
      end
      clear_period();
    end
    res.timeout      = timeout_ms;
    res.average      = period_avg;
    res.minimum      = period_min;
    res.maximum      = period_max;
    res.prev_average = prev_avg;
  endtask

  task automatic check_field(input string label, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    estimate_t want;
    if (!rst_ni) begin
      clear_period();
      timeout_ms = TIMEOUT_RESET;
      prev_avg   = '0;
      expected_q.delete();
      mismatch_count_o = 0;
      words_pending_o  = 0;
    end else begin
      if (cfg_we_i) timeout_ms = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t ns: result word with nothing outstanding, expected none, got timeout %0d",
                   $time, resend_timeout_ms_i);
        end else begin
          want = expected_q.pop_front();
          check_field("resend_timeout_ms", want.timeout, resend_timeout_ms_i);
          check_field("average_ping_ms", want.average, average_ping_ms_i);
          check_field("min_ping_ms", want.minimum, min_ping_ms_i);
          check_field("max_ping_ms", want.maximum, max_ping_ms_i);
          check_field("last_period_average_ms", want.prev_average, last_period_average_ms_i);
          check_field("sample_taken", 16'(want.taken), 16'(sample_taken_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        estimate_next(action_i, now_ms_i, send_time_ms_i, first_send_time_ms_i, was_resent_i,
                      want);
        expected_q.push_back(want);
      end
      words_pending_o = expected_q.size();
    end
  end

endmodule

### tb/resend_timeout_estimator_unit_tb.sv
// Top of the resend timeout estimator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module resend_timeout_estimator_unit_tb;
  import rtei_pkg::*;

  localparam int unsigned RUN_LIMIT = 400_000;
  localparam int unsigned WORDS_PER_SETTING = 200;
  localparam int unsigned NUM_SETTINGS = 6;
  localparam int unsigned DRAIN_CYCLES = 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = ACTION_ACK;
  logic [31:0] now_ms_i = '0;
  logic [31:0] send_time_ms_i = '0;
  logic [31:0] first_send_time_ms_i = '0;
  logic        was_resent_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] resend_timeout_ms_o;
  logic [15:0] average_ping_ms_o;
  logic [15:0] min_ping_ms_o;
  logic [15:0] max_ping_ms_o;
  logic [15:0] last_period_average_ms_o;
  logic        sample_taken_o;

  int unsigned mismatches;
  int unsigned words_pending;
  int unsigned burst_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  resend_timeout_estimator_unit u_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_data_i               (cfg_data_i),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .action_i                 (action_i),
    .now_ms_i                 (now_ms_i),
    .send_time_ms_i           (send_time_ms_i),
    .first_send_time_ms_i     (first_send_time_ms_i),
    .was_resent_i             (was_resent_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .resend_timeout_ms_o      (resend_timeout_ms_o),
    .average_ping_ms_o        (average_ping_ms_o),
    .min_ping_ms_o            (min_ping_ms_o),
    .max_ping_ms_o            (max_ping_ms_o),
    .last_period_average_ms_o (last_period_average_ms_o),
    .sample_taken_o           (sample_taken_o)
  );

  timeout_estimate_checker u_checker (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_data_i               (cfg_data_i),
    .in_valid_i               (in_valid_i),
    .in_ready_i               (in_ready_o),
    .action_i                 (action_i),
    .now_ms_i                 (now_ms_i),
    .send_time_ms_i           (send_time_ms_i),
    .first_send_time_ms_i     (first_send_time_ms_i),
    .was_resent_i             (was_resent_i),
    .out_valid_i              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .resend_timeout_ms_i      (resend_timeout_ms_o),
    .average_ping_ms_i        (average_ping_ms_o),
    .min_ping_ms_i            (min_ping_ms_o),
    .max_ping_ms_i            (max_ping_ms_o),
    .last_period_average_ms_i (last_period_average_ms_o),
    .sample_taken_i           (sample_taken_o),
    .mismatch_count_o         (mismatches),
    .words_pending_o          (words_pending)
  );

  // drop valid for a random gap between bursts, then hold the word until accepted
  task automatic offer_word(input logic act, input logic [31:0] now, input logic [31:0] sent,
                            input logic [31:0] first, input logic resent);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i           <= 1'b1;
    action_i             <= act;
    now_ms_i             <= now;
    send_time_ms_i       <= sent;
    first_send_time_ms_i <= first;
    was_resent_i         <= resent;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic ack_after(input logic [31:0] delta, input logic resent);
    logic [31:0] now;
    now = $urandom;
    if (resent) begin
      offer_word(ACTION_ACK, now, $urandom, now - delta, 1'b1);
    end else begin
      offer_word(ACTION_ACK, now, now - delta, $urandom, 1'b0);
    end
  endtask

  task automatic close_word();
    offer_word(ACTION_CLOSE, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1);
      1, 2, 3, 4, 5: return $urandom_range(0, 300);
      6, 7: return $urandom_range(300, 3000);
      8: return $urandom_range(3000, 70000);
      default: return $urandom;
    endcase
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [15:0] value);
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_random(input int unsigned words);
    int unsigned i;
    int unsigned n;
    for (i = 0; i < words; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) ack_after($urandom_range(0, 1), 1'b0);
        close_word();
      end else if ($urandom_range(0, 9) == 0) begin
        close_word();
      end else begin
        ack_after(pick_delta(), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic run_directed();
    offer_word(ACTION_CLOSE, 32'd0, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd100, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer_word(ACTION_ACK, 32'd5, 32'hFFFF_FFF0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
    offer_word(ACTION_ACK, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b0);
    offer_word(ACTION_CLOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer_word(ACTION_ACK, 32'd1000, 32'd900, 32'd200, 1'b1);
    offer_word(ACTION_ACK, 32'd0, 32'd0, 32'd1, 1'b1);
    offer_word(ACTION_CLOSE, 32'd0, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd7, 32'd7, 32'd0, 1'b0);
    offer_word(ACTION_CLOSE, 32'd0, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd50, 32'd50, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd60, 32'd60, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd70, 32'd70, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd81, 32'd80, 32'd0, 1'b0);
    offer_word(ACTION_CLOSE, 32'd0, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd65535, 32'd0, 32'd0, 1'b1);
    offer_word(ACTION_ACK, 32'd70000, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_CLOSE, 32'd0, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd10, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_CLOSE, 32'd0, 32'd0, 32'd0, 1'b0);
    offer_word(ACTION_ACK, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
    offer_word(ACTION_CLOSE, 32'd0, 32'd0, 32'd0, 1'b0);
  endtask

  initial begin : receiver
    int unsigned rx_cycle;
    int unsigned hold_left;
    int unsigned mode;
    rx_cycle  = 0;
    hold_left = 0;
    mode      = 0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle % 15000 == 5000) hold_left = 400;
      if (rx_cycle % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rx_cycle % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** resend_timeout_estimator_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    logic [15:0] setting;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    settle();
    for (k = 0; k < NUM_SETTINGS; k++) begin
      case (k)
        0: setting = 16'd65535;
        1: setting = 16'd0;
        2: setting = 16'd1;
        3: setting = 16'd333;
        4: setting = 16'd3000;
        default: setting = 16'($urandom_range(1, 65535));
      endcase
      write_setting(setting);
      run_random(WORDS_PER_SETTING);
      settle();
    end
    if (mismatches == 0 && words_pending == 0) begin
      $display("** resend_timeout_estimator_unit: PASSED **");
    end else begin
      $display("** resend_timeout_estimator_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
sv/rtei_pkg.sv
sv/rtei_div.sv
sv/resend_timeout_estimator_unit.sv
tb/timeout_estimate_checker.sv
tb/resend_timeout_estimator_unit_tb.sv
